>>> rtl/pths_pkg.sv
// Shared types and constants for the point target hit search block.
// Item and result structs, command/status structs, codes and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pths_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;

    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PTR_W  = $clog2(MAX_POINTS + 1);
    localparam int WIDE_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    localparam logic [DIFF_W-1:0] ONE_FIXED = DIFF_W'(1 << FRAC_BITS);
    localparam logic [SUM_W-1:0]  ONE_SQ    = SUM_W'(1 << (2 * FRAC_BITS));

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_QUERY  = 2'd1,
        K_REMOVE = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_SPARE    = 2'd3
    } t_status;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_kind              kind;
        t_coord             pos_x;
        t_coord             pos_y;
        logic [SLOT_W-1:0]  slot;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [CNT_W-1:0]   count_now;
        t_status            status;
    } t_result;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        logic cap;
        logic append;
        logic scan_step;
        logic shift_step;
        logic count_dec;
        logic count_clr;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic ptr_end;
        logic found;
        logic pipe_busy;
        logic ok;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/pths_ctrl.sv
// Sequencer for the point target hit search block.
// Decodes the item kind and steps the datapath through append/scan/shift/clear.
// Depends on pths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pths_ctrl import pths_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_kind i_kind,
    input  wire t_stat i_stat,
    output logic       busy,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_DRAIN,
        S_SHIFT,
        S_SHIFT_END,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.cap = 1'b1;
                    unique case (i_kind)
                        K_APPEND: n_state = S_APPEND;
                        K_QUERY:  n_state = S_SCAN;
                        K_REMOVE: n_state = S_SHIFT;
                        K_CLEAR:  n_state = S_CLEAR;
                        default:  n_state = S_CLEAR;
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.ptr_end || i_stat.found) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!i_stat.ok) begin
                    n_state = S_DONE;
                end else if (i_stat.ptr_end) begin
                    n_state = S_SHIFT_END;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_SHIFT_END: begin
                o_cmd.count_dec = 1'b1;
                n_state         = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.count_clr = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/pths_dp.sv
// Datapath for the point target hit search block: target table memory,
// scan pointer, distance pipeline (diff, square, sum/compare), result register.
// Depends on pths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pths_dp import pths_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire t_cmd  i_cmd,
    output t_stat      o_stat,
    output logic       o_valid,
    output t_result    o_result
);

    t_point              r_mem [MAX_POINTS];
    t_point              r_rd_data;
    t_coord              r_qx;
    t_coord              r_qy;
    t_status             r_status;
    logic [PTR_W-1:0]    r_count;
    logic [PTR_W-1:0]    r_ptr;

    logic [ADDR_W-1:0]   r_p0_idx;
    logic                r_p0_cmp;
    logic                r_p0_mov;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [ADDR_W-1:0]   r_p1_idx;
    logic                r_p1_vld;
    logic [SQ_W-1:0]     r_sqx;
    logic [SQ_W-1:0]     r_sqy;
    logic                r_far;
    logic [ADDR_W-1:0]   r_p2_idx;
    logic                r_p2_vld;
    logic                r_found;
    logic [ADDR_W-1:0]   r_hit_idx;
    logic                r_valid;
    t_result             r_result;

    logic [PTR_W-1:0]    n_count;
    logic [PTR_W-1:0]    n_ptr;
    t_status             n_status;
    logic [DIFF_W-1:0]   n_magx;
    logic [DIFF_W-1:0]   n_magy;
    logic [SUM_W-1:0]    n_sum;
    logic                n_near;
    logic                rd_en;

    assign rd_en = i_cmd.scan_step || i_cmd.shift_step;

    always_comb begin
        unique case (i_item.kind)
            K_APPEND: n_status = (r_count == PTR_W'(MAX_POINTS)) ? ST_FULL : ST_OK;
            K_REMOVE: n_status = (WIDE_W'(i_item.slot) >= WIDE_W'(r_count)) ?
                                 ST_BAD_SLOT : ST_OK;
            default:  n_status = ST_OK;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_clr) begin
            n_count = '0;
        end else if (i_cmd.count_dec) begin
            n_count = r_count - 1'b1;
        end else if (i_cmd.append && r_status == ST_OK) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.cap) begin
            n_ptr = (i_item.kind == K_REMOVE) ?
                    PTR_W'(WIDE_W'(i_item.slot) + 1'b1) : '0;
        end else if (rd_en) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    assign n_magx = r_dx[DIFF_W-1] ? $unsigned(-r_dx) : $unsigned(r_dx);
    assign n_magy = r_dy[DIFF_W-1] ? $unsigned(-r_dy) : $unsigned(r_dy);
    assign n_sum  = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    assign n_near = r_p2_vld && !r_far && (n_sum <= ONE_SQ);

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && r_status == ST_OK) begin
            r_mem[ADDR_W'(r_count)] <= '{x: r_qx, y: r_qy};
        end else if (r_p0_mov) begin
            r_mem[r_p0_idx - 1'b1] <= r_rd_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[ADDR_W'(r_ptr)];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_qx     <= i_item.pos_x;
            r_qy     <= i_item.pos_y;
            r_status <= n_status;
        end
        r_p0_idx <= ADDR_W'(r_ptr);
        r_dx     <= DIFF_W'(r_qx) - DIFF_W'(r_rd_data.x);
        r_dy     <= DIFF_W'(r_qy) - DIFF_W'(r_rd_data.y);
        r_p1_idx <= r_p0_idx;
        r_far    <= (n_magx > ONE_FIXED) || (n_magy > ONE_FIXED);
        r_sqx    <= n_magx[MAG_W-1:0] * n_magx[MAG_W-1:0];
        r_sqy    <= n_magy[MAG_W-1:0] * n_magy[MAG_W-1:0];
        r_p2_idx <= r_p1_idx;
        if (i_cmd.emit) begin
            r_result.hit       <= r_found;
            r_result.hit_slot  <= SLOT_W'(r_hit_idx);
            r_result.count_now <= CNT_W'(r_count);
            r_result.status    <= r_status;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_p0_cmp  <= 1'b0;
            r_p0_mov  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_hit_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_p0_cmp <= i_cmd.scan_step;
            r_p0_mov <= i_cmd.shift_step;
            r_p1_vld <= r_p0_cmp;
            r_p2_vld <= r_p1_vld;
            r_valid  <= i_cmd.emit;
            if (i_cmd.cap) begin
                r_found   <= 1'b0;
                r_hit_idx <= '0;
            end else if (n_near && !r_found) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_p2_idx;
            end
        end
    end

    assign o_stat.ptr_end   = (r_ptr >= r_count);
    assign o_stat.found     = r_found;
    assign o_stat.pipe_busy = r_p0_cmp || r_p1_vld || r_p2_vld;
    assign o_stat.ok        = (r_status == ST_OK);
    assign o_valid          = r_valid;
    assign o_result         = r_result;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(MAX_POINTS))
        else $error("table count above capacity");

    a_move_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p0_mov |-> (PTR_W'(r_p0_idx) < r_count) && (r_p0_idx != '0))
        else $error("shift transfer outside stored targets");

    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found && !i_cmd.cap |=> r_found && $stable(r_hit_idx))
        else $error("first hit overwritten during scan");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.hit |-> r_result.status == ST_OK)
        else $error("hit reported with error status");

endmodule

`default_nettype wire

>>> rtl/point_target_hit_search.sv
// Top level of the point target hit search block.
// Joins the pths_ctrl sequencer and the pths_dp datapath. Depends on pths_pkg.
//
//   channel   handshake               payload            transfer when
//   item in   start / busy            i_item (t_item)    start && !busy
//   result    o_valid (1-cycle pulse) o_result (t_result) o_valid high
//
// Append, clear and a remove at an unstored slot go from their action state to done.
// Query: table reads at one per cycle into a 3-stage distance pipeline, ending at
// the count or three reads past the first hit; the pipeline drains before done.
// Remove: one entry moved per cycle through the one write port, slot + 1 to count.
// Reset empties the table; stored coordinates are not cleared. Results cannot be
// stalled; busy holds off items.
`timescale 1ns / 1ps
`default_nettype none

module point_target_hit_search import pths_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_item i_item,
    output logic       busy,
    output logic       o_valid,
    output t_result    o_result
);

    t_cmd  cmd;
    t_stat stat;

    pths_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    pths_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
